FILE: rtl/alld_pkg.sv
// Shared types and constants for the ambient light LED dimmer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package alld_pkg;

  localparam int LUX_WIDTH_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int LVL_W         = 3;
  localparam int APB_AW        = 5;
  localparam int APB_DW        = 32;

  localparam int BRIGHT_LIMIT  = 5000;
  localparam int OFF_BAND      = 3;

  localparam logic [CFG_W-1:0] DISABLE_THR_RST = 16'd10;
  localparam logic [CFG_W-1:0] DIM_THR_RST     = 16'd20;
  localparam logic [CFG_W-1:0] FULL_SCALE_RST  = 16'd500;
  localparam logic [LVL_W-1:0] MIN_BRIGHT_RST  = 3'd0;
  localparam logic [LVL_W-1:0] MAX_BRIGHT_RST  = 3'd7;
  localparam logic [LVL_W-1:0] STEP_HYST_RST   = 3'd1;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_DISABLE_THR = 3'd0,
    REG_DIM_THR     = 3'd1,
    REG_FULL_SCALE  = 3'd2,
    REG_MIN_BRIGHT  = 3'd3,
    REG_MAX_BRIGHT  = 3'd4,
    REG_STEP_HYST   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] disable_thr;
    logic [CFG_W-1:0] dim_thr;
    logic [CFG_W-1:0] full_scale;
    logic [LVL_W-1:0] min_bright;
    logic [LVL_W-1:0] max_bright;
    logic [LVL_W-1:0] step_hyst;
  } cfg_t;

endpackage

FILE: rtl/alld_if.sv
// Valid/ready channel interfaces for the dimmer: light samples in, results out.
// Depends on alld_pkg.
`timescale 1ns / 1ps

interface alld_sample_if #(parameter int LUX_W = alld_pkg::LUX_WIDTH_DEF);
  logic             valid;
  logic             ready;
  logic [LUX_W-1:0] lux;
  logic             is_night;

  modport source (output valid, lux, is_night, input ready);
  modport sink   (input valid, lux, is_night, output ready);
endinterface

interface alld_result_if;
  import alld_pkg::*;

  logic             valid;
  logic             ready;
  action_t          action;
  logic [LVL_W-1:0] level;
  logic             lit;

  modport source (output valid, action, level, lit, input ready);
  modport sink   (input valid, action, level, lit, output ready);
endinterface

FILE: rtl/alld_cfg.sv
// APB-style register file holding the dimmer's six configuration registers.
// Depends on alld_pkg.
`timescale 1ns / 1ps

module alld_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [alld_pkg::APB_AW-1:0]   paddr,
  input  logic [alld_pkg::APB_DW-1:0]   pwdata,
  output logic [alld_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output alld_pkg::cfg_t                cfg
);
  import alld_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disable_thr <= DISABLE_THR_RST;
      cfg.dim_thr     <= DIM_THR_RST;
      cfg.full_scale  <= FULL_SCALE_RST;
      cfg.min_bright  <= MIN_BRIGHT_RST;
      cfg.max_bright  <= MAX_BRIGHT_RST;
      cfg.step_hyst   <= STEP_HYST_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DISABLE_THR: cfg.disable_thr <= pwdata[CFG_W-1:0];
        REG_DIM_THR:     cfg.dim_thr     <= pwdata[CFG_W-1:0];
        REG_FULL_SCALE:  cfg.full_scale  <= pwdata[CFG_W-1:0];
        REG_MIN_BRIGHT:  cfg.min_bright  <= pwdata[LVL_W-1:0];
        REG_MAX_BRIGHT:  cfg.max_bright  <= pwdata[LVL_W-1:0];
        REG_STEP_HYST:   cfg.step_hyst   <= pwdata[LVL_W-1:0];
        default: ;  // unmapped slots ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DISABLE_THR: prdata = APB_DW'(cfg.disable_thr);
      REG_DIM_THR:     prdata = APB_DW'(cfg.dim_thr);
      REG_FULL_SCALE:  prdata = APB_DW'(cfg.full_scale);
      REG_MIN_BRIGHT:  prdata = APB_DW'(cfg.min_bright);
      REG_MAX_BRIGHT:  prdata = APB_DW'(cfg.max_bright);
      REG_STEP_HYST:   prdata = APB_DW'(cfg.step_hyst);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/alld_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on alld_pkg (widths come in as parameters from the top level).
`timescale 1ns / 1ps

module alld_div #(
  parameter int NUM_W = alld_pkg::LUX_WIDTH_DEF + 3,
  parameter int DEN_W = alld_pkg::CFG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);
  import alld_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] sub;
  logic             qbit;

  // Shift the next dividend bit into the partial remainder, try the subtract.
  assign trial = {rem[DEN_W-1:0], quotient[NUM_W-1]};
  assign sub   = {1'b0, trial} - {2'b00, dvs};
  assign qbit  = !sub[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= qbit ? sub[DEN_W:0] : trial;
      quotient <= {quotient[NUM_W-2:0], qbit};
    end
  end

endmodule

FILE: rtl/ambient_light_led_dimmer_core.sv
// Ambient light LED dimmer: top level with sequencer, hysteresis latch and mapping.
// Depends on alld_pkg, alld_if, alld_cfg and alld_div.
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Handshake
// --------  ---  ------------------------------  --------------------------
// sample    in   lux[LUX_WIDTH], is_night        valid/ready
// result    out  action[2], level[3], lit        valid/ready
// apb       in   paddr[5], pwdata[32] -> prdata  psel/penable/pwrite/pready
//
// When the linear mapping runs, a sample goes from S_EVAL through the bit-serial
// divider (LUX_WIDTH+3 quotient bits) and S_HYST to S_EMIT; a zero divisor skips
// the divider, and all other samples go from S_EVAL straight to S_EMIT.
// ready is high only while the sequencer idles. A finished result sits in the
// output register and a new sample can be taken behind it; the next result
// waits for it.
// rst is synchronous: config back to defaults, latch clear, display lit.

module ambient_light_led_dimmer_core #(
  parameter int LUX_WIDTH = alld_pkg::LUX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  alld_sample_if.sink                 sample,
  alld_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alld_pkg::APB_AW-1:0] paddr,
  input  logic [alld_pkg::APB_DW-1:0] pwdata,
  output logic [alld_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import alld_pkg::*;

  // Product (lux-dim)*|max-min| fits LUX_WIDTH+3 bits.
  localparam int NUM_W = LUX_WIDTH + 3;
  // Compare width: room for threshold+band and the bright limit.
  localparam int CMP_W = ((LUX_WIDTH > CFG_W) ? LUX_WIDTH : CFG_W) + 2;
  // Signed mapped value before clamping.
  localparam int NB_W  = NUM_W + 2;
  localparam int HY_W  = LVL_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_HYST,
    S_EMIT
  } state_t;

  state_t state;

  cfg_t cfg;

  // Sample and persistent state.
  logic [LUX_WIDTH-1:0] lux_r;
  logic                 night_r;
  logic                 off_latched;
  logic [LVL_W-1:0]     held_level;
  logic                 lit_flag;

  // Pending result, loaded into the output register in S_EMIT.
  action_t              pend_action;
  logic [LVL_W-1:0]     pend_level;

  // Output register.
  logic                 out_valid;
  action_t              out_action;
  logic [LVL_W-1:0]     out_level;
  logic                 out_lit;

  // Divider hookup.
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_num;
  logic [CFG_W-1:0]     div_den;
  logic [NUM_W-1:0]     div_quo;
  logic                 neg_r;
  logic signed [NB_W-1:0] nb_r;

  alld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alld_div #(
    .NUM_W (NUM_W),
    .DEN_W (CFG_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------
  // Decision logic for S_EVAL
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0]       lux_x, thr_x, dim_x;
  logic                   bright;
  logic                   off_next;
  logic                   above_dim;
  logic                   at_or_below_thr;
  logic [LUX_WIDTH-1:0]   lux_diff;
  logic signed [LVL_W:0]  span;
  logic [LVL_W-1:0]       span_mag;
  logic signed [CFG_W:0]  den_s;
  logic [CFG_W-1:0]       den_mag;
  logic [NUM_W-1:0]       prod;

  assign lux_x  = CMP_W'(lux_r);
  assign thr_x  = CMP_W'(cfg.disable_thr);
  assign dim_x  = CMP_W'(cfg.dim_thr);
  assign bright = lux_x >= CMP_W'(BRIGHT_LIMIT);

  // Switch-off latch with a band of OFF_BAND lux on each side of the threshold.
  // A threshold below the band has a negative lower edge: never latches.
  always_comb begin
    if (off_latched) begin
      off_next = !(lux_x > thr_x + CMP_W'(OFF_BAND));
    end else begin
      off_next = night_r && (thr_x >= CMP_W'(OFF_BAND)) &&
                 (lux_x + CMP_W'(OFF_BAND) <= thr_x);
    end
  end

  assign above_dim       = lux_x > dim_x;
  assign at_or_below_thr = lux_x <= thr_x;

  // Only used when lux > dim, so the difference is positive and fits.
  assign lux_diff = LUX_WIDTH'(lux_x - dim_x);
  assign span     = $signed({1'b0, cfg.max_bright}) - $signed({1'b0, cfg.min_bright});
  assign span_mag = span[LVL_W] ? LVL_W'(-span) : span[LVL_W-1:0];
  assign den_s    = $signed({1'b0, cfg.full_scale}) - $signed({1'b0, cfg.dim_thr});
  assign den_mag  = den_s[CFG_W] ? CFG_W'(-den_s) : den_s[CFG_W-1:0];
  assign prod     = NUM_W'(lux_diff) * NUM_W'(span_mag);

  // ---------------------------------------------------------------------
  // Signed quotient plus min, then clamp and hysteresis (S_DIV / S_HYST)
  // ---------------------------------------------------------------------
  logic signed [NB_W-1:0] q_s;
  logic signed [NB_W-1:0] nb_div;
  logic signed [NB_W-1:0] lo_s, hi_s;
  logic [LVL_W-1:0]       clamped;
  logic signed [HY_W-1:0] cl5, held5, hy5;
  logic                   adopt;

  assign q_s    = $signed({2'b00, div_quo});
  assign lo_s   = $signed(NB_W'(cfg.min_bright));
  assign hi_s   = $signed(NB_W'(cfg.max_bright));
  assign nb_div = (neg_r ? -q_s : q_s) + lo_s;

  // Lower bound checked first; with min above max, a value below min resolves to min, any other to max.
  always_comb begin
    if (nb_r < lo_s) begin
      clamped = cfg.min_bright;
    end else if (nb_r > hi_s) begin
      clamped = cfg.max_bright;
    end else begin
      clamped = nb_r[LVL_W-1:0];
    end
  end

  assign cl5   = $signed(HY_W'(clamped));
  assign held5 = $signed(HY_W'(held_level));
  assign hy5   = $signed(HY_W'(cfg.step_hyst));
  assign adopt = (cl5 > held5 + hy5) || (cl5 < held5 - hy5);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  // Result moves into the output register once that register is free or
  // being drained in the same cycle.
  logic emit;

  assign emit          = (state == S_EMIT) && (!out_valid || result.ready);
  assign sample.ready  = (state == S_IDLE);
  assign result.valid  = out_valid;
  assign result.action = out_action;
  assign result.level  = out_level;
  assign result.lit    = out_lit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      off_latched <= 1'b0;
      held_level  <= MIN_BRIGHT_RST;
      lit_flag    <= 1'b1;
      out_valid   <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (bright) begin
            // very bright: nothing changes
            pend_action <= ACT_NONE;
            pend_level  <= '0;
            state       <= S_EMIT;
          end else begin
            off_latched <= off_next;
            if (off_next) begin
              pend_action <= ACT_CLEAR;
              pend_level  <= '0;
              lit_flag    <= 1'b0;
              state       <= S_EMIT;
            end else if (!above_dim) begin
              pend_action <= ACT_SET;
              pend_level  <= '0;
              lit_flag    <= 1'b1;
              state       <= S_EMIT;
            end else if (at_or_below_thr) begin
              // dim threshold below disable threshold: snap to min
              pend_action <= ACT_SET;
              pend_level  <= cfg.min_bright;
              held_level  <= cfg.min_bright;
              lit_flag    <= 1'b1;
              state       <= S_EMIT;
            end else if (den_mag == '0) begin
              // zero divisor maps to max before clamp
              pend_action <= ACT_SET;
              lit_flag    <= 1'b1;
              nb_r        <= hi_s;
              state       <= S_HYST;
            end else begin
              pend_action <= ACT_SET;
              lit_flag    <= 1'b1;
              div_start   <= 1'b1;
              state       <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            nb_r  <= nb_div;
            state <= S_HYST;
          end
        end

        S_HYST: begin
          if (adopt) begin
            held_level <= clamped;
            pend_level <= clamped;
          end else begin
            pend_level <= held_level;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample.valid) begin
      lux_r   <= sample.lux;
      night_r <= sample.is_night;
    end
    if (state == S_EVAL) begin
      div_num <= prod;
      div_den <= den_mag;
      neg_r   <= span[LVL_W] ^ den_s[CFG_W];
    end
    if (emit) begin
      out_action <= pend_action;
      out_level  <= pend_level;
      out_lit    <= lit_flag;
    end
  end

endmodule
